/* src/gcdlcm_pkg.sv */
// Shared types for the GCD / LCM unit.
// No dependencies; imported by gcdlcm_core and gcd_lcm_unit.
package gcdlcm_pkg;

   // control from the top level into the sequencer
   typedef struct packed {
      logic start;  // request accepted this cycle
      logic take;   // finished result moves into the output register
   } ctl_type;

   // status from the sequencer back to the top level
   typedef struct packed {
      logic idle;   // ready for a new request
      logic done;   // result held, waiting for take
   } sts_type;

endpackage

/* src/gcd_lcm_unit.sv */
// Top level of the GCD / LCM unit: request handshake and output register.
// Depends on gcdlcm_pkg and gcdlcm_core.
//
// Usage:
//   A request carries req_first_operand and req_second_operand and is taken
//   on a rising edge with req_valid high and req_stall low. Each request gives
//   exactly one response: rsp_common_divisor (gcd) and rsp_common_multiple
//   (a*b/gcd at double width), handed over when rsp_valid is high and
//   rsp_stall low. If either operand is zero the response is divisor 1,
//   multiple 0.
//   One request is worked on at a time; req_stall stays high while it is.
//   A zero operand goes straight to the finished state. Otherwise a binary
//   GCD (one shift or one subtract/swap per cycle through the shared
//   subtractor) runs first, then restoring division on the same subtractor,
//   then a multiply step and the move into the output register.
//   A finished response waits in the output register while rsp_stall is
//   high, and the next request is accepted meanwhile.
//   Reset (synchronous, active high) drops rsp_valid and returns to idle.
module gcd_lcm_unit #(
   parameter int unsigned OPERAND_BITS = 31
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [OPERAND_BITS-1:0]     req_first_operand,
   input  logic [OPERAND_BITS-1:0]     req_second_operand,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [OPERAND_BITS-1:0]     rsp_common_divisor,
   output logic [2*OPERAND_BITS-1:0]   rsp_common_multiple
);
   import gcdlcm_pkg::*;

   ctl_type                     ctl;
   sts_type                     sts;
   logic [OPERAND_BITS-1:0]     core_divisor;
   logic [2*OPERAND_BITS-1:0]   core_multiple;

   logic                        rsp_valid_ff, rsp_valid_in;
   logic [OPERAND_BITS-1:0]     rsp_divisor_ff, rsp_divisor_in;
   logic [2*OPERAND_BITS-1:0]   rsp_multiple_ff, rsp_multiple_in;

   assign req_stall = ~sts.idle;
   assign ctl.start = req_valid & ~req_stall;
   assign ctl.take  = sts.done & (~rsp_valid_ff | ~rsp_stall);

   gcdlcm_core #(.OPERAND_BITS(OPERAND_BITS)) u_core (
      .clock           (clock),
      .reset           (reset),
      .ctl             (ctl),
      .first_operand   (req_first_operand),
      .second_operand  (req_second_operand),
      .sts             (sts),
      .common_divisor  (core_divisor),
      .common_multiple (core_multiple)
   );

   always_comb begin
      rsp_valid_in    = rsp_valid_ff;
      rsp_divisor_in  = rsp_divisor_ff;
      rsp_multiple_in = rsp_multiple_ff;
      priority if (ctl.take) begin
         rsp_valid_in    = 1'b1;
         rsp_divisor_in  = core_divisor;
         rsp_multiple_in = core_multiple;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_divisor_ff  <= rsp_divisor_in;
      rsp_multiple_ff <= rsp_multiple_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_common_divisor  = rsp_divisor_ff;
   assign rsp_common_multiple = rsp_multiple_ff;

   // an accepted request keeps the core busy in the next cycle
   a_busy_after_start: assert property (@(posedge clock) disable iff (reset)
      ctl.start |=> !sts.idle)
      else $error("core idle right after accepting a request");

   a_divisor_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_common_divisor != '0))
      else $error("zero divisor in response");

   // a zero multiple only comes from the zero operand path
   a_zero_multiple: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_common_multiple == '0) |-> (rsp_common_divisor == 1))
      else $error("zero multiple with divisor other than one");

endmodule

/* src/gcdlcm_sub.sv */
// Shared subtract / compare unit of the GCD / LCM unit.
// No dependencies; used by gcdlcm_core for both the GCD and division phases.
module gcdlcm_sub #(
   parameter int unsigned WIDTH = 32
) (
   input  logic [WIDTH-1:0] lhs,
   input  logic [WIDTH-1:0] rhs,
   output logic [WIDTH-1:0] diff,
   output logic             ge
);

   logic [WIDTH:0] sum;

   assign sum  = {1'b0, lhs} - {1'b0, rhs};
   assign diff = sum[WIDTH-1:0];
   assign ge   = ~sum[WIDTH];

endmodule

/* src/gcdlcm_core.sv */
// Sequencer and datapath registers: binary GCD, restoring division, multiply.
// Depends on gcdlcm_pkg and gcdlcm_sub.
module gcdlcm_core #(
   parameter int unsigned OPERAND_BITS = 31
) (
   input  logic                        clock,
   input  logic                        reset,
   input  gcdlcm_pkg::ctl_type         ctl,
   input  logic [OPERAND_BITS-1:0]     first_operand,
   input  logic [OPERAND_BITS-1:0]     second_operand,
   output gcdlcm_pkg::sts_type         sts,
   output logic [OPERAND_BITS-1:0]     common_divisor,
   output logic [2*OPERAND_BITS-1:0]   common_multiple
);
   import gcdlcm_pkg::*;

   localparam int unsigned N    = OPERAND_BITS;
   localparam int unsigned WIDE = 2 * OPERAND_BITS;
   localparam int unsigned KW   = $clog2(OPERAND_BITS);

   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_GCD  = 5'b00010,
      ST_DIV  = 5'b00100,
      ST_MUL  = 5'b01000,
      ST_DONE = 5'b10000
   } state_type;

   state_type         state_ff, state_in;
   logic [N-1:0]      x_ff, x_in;
   logic [N-1:0]      y_ff, y_in;
   logic [KW-1:0]     k_ff, k_in;
   logic [N-1:0]      a_ff, a_in;      // first operand, then quotient
   logic [N-1:0]      b_ff, b_in;
   logic [N-1:0]      gcd_ff, gcd_in;
   logic [N-1:0]      rem_ff, rem_in;
   logic [KW-1:0]     cnt_ff, cnt_in;
   logic [WIDE-1:0]   prod_ff, prod_in;

   logic [N:0]        sub_lhs, sub_rhs, sub_diff;
   logic              sub_ge;
   logic [N:0]        trial;

   assign trial = {rem_ff, a_ff[N-1]};

   always_comb begin
      if (state_ff == ST_GCD) begin
         sub_lhs = {1'b0, x_ff};
         sub_rhs = {1'b0, y_ff};
      end else begin
         sub_lhs = trial;
         sub_rhs = {1'b0, gcd_ff};
      end
   end

   gcdlcm_sub #(.WIDTH(N + 1)) u_sub (
      .lhs  (sub_lhs),
      .rhs  (sub_rhs),
      .diff (sub_diff),
      .ge   (sub_ge)
   );

   always_comb begin
      state_in = state_ff;
      x_in     = x_ff;
      y_in     = y_ff;
      k_in     = k_ff;
      a_in     = a_ff;
      b_in     = b_ff;
      gcd_in   = gcd_ff;
      rem_in   = rem_ff;
      cnt_in   = cnt_ff;
      prod_in  = prod_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (ctl.start) begin
               a_in = first_operand;
               b_in = second_operand;
               x_in = first_operand;
               y_in = second_operand;
               k_in = '0;
               if (first_operand == '0 || second_operand == '0) begin
                  gcd_in   = N'(1);
                  prod_in  = '0;
                  state_in = ST_DONE;
               end else begin
                  state_in = ST_GCD;
               end
            end
         end
         ST_GCD: begin
            priority if (x_ff == '0 || y_ff == '0) begin
               gcd_in   = (x_ff | y_ff) << k_ff;
               rem_in   = '0;
               cnt_in   = '0;
               state_in = ST_DIV;
            end else if (!x_ff[0] && !y_ff[0]) begin
               x_in = x_ff >> 1;
               y_in = y_ff >> 1;
               k_in = k_ff + 1'b1;
            end else if (!x_ff[0]) begin
               x_in = x_ff >> 1;
            end else if (!y_ff[0]) begin
               y_in = y_ff >> 1;
            end else if (sub_ge) begin
               x_in = sub_diff[N-1:0];
            end else begin
               // keep x the larger one for the next subtract
               x_in = y_ff;
               y_in = x_ff;
            end
         end
         ST_DIV: begin
            if (sub_ge) begin
               rem_in = sub_diff[N-1:0];
            end else begin
               rem_in = trial[N-1:0];
            end
            a_in   = {a_ff[N-2:0], sub_ge};
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == KW'(N - 1)) begin
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            prod_in  = WIDE'(a_ff) * WIDE'(b_ff);
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (ctl.take) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
      x_ff    <= x_in;
      y_ff    <= y_in;
      k_ff    <= k_in;
      a_ff    <= a_in;
      b_ff    <= b_in;
      gcd_ff  <= gcd_in;
      rem_ff  <= rem_in;
      cnt_ff  <= cnt_in;
      prod_ff <= prod_in;
   end

   assign sts.idle        = (state_ff == ST_IDLE);
   assign sts.done        = (state_ff == ST_DONE);
   assign common_divisor  = gcd_ff;
   assign common_multiple = prod_ff;

endmodule
